// File: src/snm_pkg.sv
`timescale 1ns / 1ps

package snm_pkg;

    // Fixed point format shared by every stage.
    localparam int FRAC_BITS = 18;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam logic [MAG_W-1:0] Q_ONE  = MAG_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0] Q_HALF = MAG_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W:0]   THRESH_Q = (MAG_W+1)'(261882);

    typedef struct packed {
        logic [7:0] column;
        logic [7:0] row;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_out;

    // Carried alongside the first square root and the reciprocal.
    typedef struct packed {
        logic             xs;
        logic             ys;
        logic [MAG_W-1:0] xm;
        logic [MAG_W-1:0] ym;
        logic             norm;
    } t_side_a;

    // Carried alongside the ratio divider.
    typedef struct packed {
        logic             xs;
        logic             ys;
        logic [MAG_W-1:0] xm;
        logic [MAG_W-1:0] ym;
        logic [MAG_W-1:0] cb;
        logic             zero;
    } t_side_b;

    // Carried alongside the height square root.
    typedef struct packed {
        logic             xs;
        logic             ys;
        logic [MAG_W-1:0] xm;
        logic [MAG_W-1:0] ym;
        logic             zero;
    } t_side_c;

    // Sign and magnitude to the 8-bit colour code, clamped to 0..255.
    function automatic logic [7:0] encode(input logic [MAG_W-1:0] mag, input logic neg);
        logic signed [27:0] v;
        logic signed [27:0] t;
        logic signed [27:0] e;
        v = $signed({9'b0, mag});
        if (neg) begin
            v = -v;
        end
        t = v * 28'sd127 + 28'sd33423360;
        e = t >>> FRAC_BITS;
        if (t < 0) begin
            encode = 8'd0;
        end else if (e > 28'sd255) begin
            encode = 8'd255;
        end else begin
            encode = e[7:0];
        end
    endfunction

endpackage

// File: src/snm_sqrt_pipe.sv
`timescale 1ns / 1ps

// Integer square root, one result bit per register stage.
module snm_sqrt_pipe #(
    parameter int RAD_W  = 38,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int ROOT_W = RAD_W / 2;

    logic                r_v    [ROOT_W];
    logic [RAD_W-1:0]    r_rad  [ROOT_W];
    logic [ROOT_W+1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [SIDE_W-1:0]   r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              w_v;
        logic [RAD_W-1:0]  w_rad;
        logic [ROOT_W+1:0] w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [SIDE_W-1:0] w_side;
        logic [ROOT_W+1:0] w_acc;
        logic [ROOT_W+1:0] w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_acc   = {w_rem[ROOT_W-1:0], w_rad[RAD_W-1:RAD_W-2]};
        assign w_trial = {w_root, 2'b01};
        assign w_ge    = (w_acc >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= w_rad << 2;
                r_rem[k]  <= w_ge ? (w_acc - w_trial) : w_acc;
                r_root[k] <= {w_root[ROOT_W-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// File: src/snm_div_pipe.sv
`timescale 1ns / 1ps

// Fractional divider, one quotient bit per register stage:
// o_quot = floor(i_rem * 2^QUOT_W / i_den), valid while i_rem < i_den.
module snm_div_pipe #(
    parameter int QUOT_W = 19,
    parameter int DEN_W  = 19,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [DEN_W-1:0]   i_rem,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [QUOT_W-1:0]  o_quot,
    output logic [SIDE_W-1:0]  o_side
);

    logic                r_v    [QUOT_W];
    logic [DEN_W-1:0]    r_rem  [QUOT_W];
    logic [DEN_W-1:0]    r_den  [QUOT_W];
    logic [QUOT_W-1:0]   r_quot [QUOT_W];
    logic [SIDE_W-1:0]   r_side [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic              w_v;
        logic [DEN_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [QUOT_W-1:0] w_quot;
        logic [SIDE_W-1:0] w_side;
        logic [DEN_W:0]    w_two;
        logic [DEN_W:0]    w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_rem;
            assign w_den  = i_den;
            assign w_quot = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quot = r_quot[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_two  = {w_rem, 1'b0};
        assign w_ge   = (w_two >= {1'b0, w_den});
        assign w_diff = w_two - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[DEN_W-1:0] : w_two[DEN_W-1:0];
                r_den[k]  <= w_den;
                r_quot[k] <= {w_quot[QUOT_W-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[QUOT_W-1];
    assign o_quot  = r_quot[QUOT_W-1];
    assign o_side  = r_side[QUOT_W-1];

endmodule

// File: src/sphere_normal_map_pixel_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Valid    Ready    Payload
// pixel in  input      i_valid  o_ready  i_data  (column, row)
// normal    output     o_valid  i_ready  o_data  (red, green, blue)
//
// One pixel is accepted every clock while the output is not stalled. Each beat
// passes through 83 register stages; the depth is set by the two 19-stage square
// roots and the 19-stage and 18-stage dividers.
// Reset is synchronous and active low; it clears only the valid bits.
// All stages advance together: while a finished beat waits at the output the
// whole pipeline holds and o_ready is low, so nothing is lost or repeated.
module sphere_normal_map_pixel_unit #(
    parameter int MAP_SIZE = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  snm_pkg::t_pixel_in i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output snm_pkg::t_pixel_out o_data
);

    localparam int MW = snm_pkg::MAG_W;
    localparam int FB = snm_pkg::FRAC_BITS;
    localparam longint LAST = longint'(MAP_SIZE) - 1;

    // The whole pipeline moves whenever the output register is free.
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Coordinate table: the magnitude of round((2c - LAST) * 2^18 / LAST) for every
    // possible column or row, with positions beyond the map saturated.
    logic [MW-1:0] w_lut_mag [256];
    logic          w_lut_neg [256];

    for (genvar c = 0; c < 256; c++) begin : g_lut
        localparam longint CS  = (longint'(c) > LAST) ? LAST : longint'(c);
        localparam longint N2  = 2 * CS - LAST;
        localparam longint AN  = (N2 < 0) ? -N2 : N2;
        localparam longint MAG = ((AN <<< 18) + LAST / 2) / LAST;
        assign w_lut_mag[c] = MW'(MAG);
        assign w_lut_neg[c] = (N2 < 0);
    end

    // Stage 1: table lookup. The row axis is flipped, so its sign inverts.
    logic          r1_v;
    logic          r1_xs, r1_ys;
    logic [MW-1:0] r1_xm, r1_ym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_xm <= w_lut_mag[i_data.column];
            r1_xs <= w_lut_neg[i_data.column];
            r1_ym <= w_lut_mag[i_data.row];
            r1_ys <= !w_lut_neg[i_data.row];
        end
    end

    // Stage 2: rounded squares of both coordinates.
    logic [2*MW-1:0] w2_pxx, w2_pyy;
    logic          r2_v;
    logic          r2_xs, r2_ys;
    logic [MW-1:0] r2_xm, r2_ym, r2_xx, r2_yy;

    assign w2_pxx = (2*MW)'(r1_xm) * (2*MW)'(r1_xm) + (2*MW)'(snm_pkg::Q_HALF);
    assign w2_pyy = (2*MW)'(r1_ym) * (2*MW)'(r1_ym) + (2*MW)'(snm_pkg::Q_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_xs <= r1_xs;
            r2_ys <= r1_ys;
            r2_xm <= r1_xm;
            r2_ym <= r1_ym;
            r2_xx <= w2_pxx[FB+MW-1:FB];
            r2_yy <= w2_pyy[FB+MW-1:FB];
        end
    end

    // Stage 3: squared length, the edge test and the square root radicand.
    logic [MW:0]       w3_len;
    logic              r3_v;
    logic [2*MW-1:0]   r3_rad;
    snm_pkg::t_side_a  r3_side;

    assign w3_len = (MW+1)'(r2_xx) + (MW+1)'(r2_yy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rad       <= {w3_len, {FB{1'b0}}};
            r3_side.xs   <= r2_xs;
            r3_side.ys   <= r2_ys;
            r3_side.xm   <= r2_xm;
            r3_side.ym   <= r2_ym;
            r3_side.norm <= (w3_len > snm_pkg::THRESH_Q);
        end
    end

    // Length of the vector, then its reciprocal 2^36 / s.
    logic             w_s1_v;
    logic [MW-1:0]    w_s1_root;
    snm_pkg::t_side_a w_s1_side;
    logic [MW-1:0]    w_s1_den;

    snm_sqrt_pipe #(
        .RAD_W  (2*MW),
        .SIDE_W ($bits(snm_pkg::t_side_a))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_rad   (r3_rad),
        .i_side  (r3_side),
        .o_valid (w_s1_v),
        .o_root  (w_s1_root),
        .o_side  (w_s1_side)
    );

    assign w_s1_den = (w_s1_root == '0) ? MW'(1) : w_s1_root;

    logic             w_d1_v;
    logic [MW-1:0]    w_d1_inv;
    snm_pkg::t_side_a w_d1_side;

    snm_div_pipe #(
        .QUOT_W (MW),
        .DEN_W  (MW),
        .SIDE_W ($bits(snm_pkg::t_side_a))
    ) u_inv_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s1_v),
        .i_rem   (snm_pkg::Q_HALF),
        .i_den   (w_s1_den),
        .i_side  (w_s1_side),
        .o_valid (w_d1_v),
        .o_quot  (w_d1_inv),
        .o_side  (w_d1_side)
    );

    // Stage 4: scale both coordinates onto the unit circle at the rim.
    logic [2*MW-1:0] w4_px, w4_py;
    logic          r4_v;
    logic          r4_xs, r4_ys;
    logic [MW-1:0] r4_xm, r4_ym;

    assign w4_px = (2*MW)'(w_d1_side.xm) * (2*MW)'(w_d1_inv) + (2*MW)'(snm_pkg::Q_HALF);
    assign w4_py = (2*MW)'(w_d1_side.ym) * (2*MW)'(w_d1_inv) + (2*MW)'(snm_pkg::Q_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_xs <= w_d1_side.xs;
            r4_ys <= w_d1_side.ys;
            r4_xm <= w_d1_side.norm ? w4_px[FB+MW-1:FB] : w_d1_side.xm;
            r4_ym <= w_d1_side.norm ? w4_py[FB+MW-1:FB] : w_d1_side.ym;
        end
    end

    // Stage 5: squares of the final coordinates.
    logic [2*MW-1:0] w5_pxx, w5_pyy;
    logic          r5_v;
    logic          r5_xs, r5_ys;
    logic [MW-1:0] r5_xm, r5_ym, r5_xsq, r5_ysq;

    assign w5_pxx = (2*MW)'(r4_xm) * (2*MW)'(r4_xm) + (2*MW)'(snm_pkg::Q_HALF);
    assign w5_pyy = (2*MW)'(r4_ym) * (2*MW)'(r4_ym) + (2*MW)'(snm_pkg::Q_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_xs  <= r4_xs;
            r5_ys  <= r4_ys;
            r5_xm  <= r4_xm;
            r5_ym  <= r4_ym;
            r5_xsq <= w5_pxx[FB+MW-1:FB];
            r5_ysq <= w5_pyy[FB+MW-1:FB];
        end
    end

    // Stage 6: height base 1 - y^2. The height is zero when the base is not
    // positive, or when x^2 reaches the base so that the ratio is one or more.
    logic signed [MW+1:0] w6_cb;
    logic                 w6_cb_pos;
    logic                 r6_v;
    logic [MW-1:0]        r6_xsq;
    snm_pkg::t_side_b     r6_side;

    assign w6_cb     = $signed({2'b0, snm_pkg::Q_ONE}) - $signed({2'b0, r5_ysq});
    assign w6_cb_pos = !w6_cb[MW+1] && (w6_cb != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_xsq       <= r5_xsq;
            r6_side.xs   <= r5_xs;
            r6_side.ys   <= r5_ys;
            r6_side.xm   <= r5_xm;
            r6_side.ym   <= r5_ym;
            r6_side.cb   <= w6_cb[MW-1:0];
            r6_side.zero <= !w6_cb_pos || ({2'b0, r5_xsq} >= w6_cb[MW+1:0]);
        end
    end

    // Ratio x^2 / (1 - y^2), below one whenever the height is not forced to zero.
    logic             w_d2_v;
    logic [FB-1:0]    w_d2_ratio;
    snm_pkg::t_side_b w_d2_side;

    snm_div_pipe #(
        .QUOT_W (FB),
        .DEN_W  (MW),
        .SIDE_W ($bits(snm_pkg::t_side_b))
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_rem   (r6_xsq),
        .i_den   (r6_side.cb),
        .i_side  (r6_side),
        .o_valid (w_d2_v),
        .o_quot  (w_d2_ratio),
        .o_side  (w_d2_side)
    );

    // Stage 7: product (1 - ratio) * (1 - y^2), rounded, as the height radicand.
    logic [MW-1:0]    w7_sa;
    logic [2*MW-1:0]  w7_prod;
    logic             r7_v;
    logic [2*MW-1:0]  r7_rad;
    snm_pkg::t_side_c r7_side;

    assign w7_sa   = snm_pkg::Q_ONE - MW'(w_d2_ratio);
    assign w7_prod = (2*MW)'(w7_sa) * (2*MW)'(w_d2_side.cb) + (2*MW)'(snm_pkg::Q_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_rad       <= {w7_prod[FB+MW-1:FB], {FB{1'b0}}};
            r7_side.xs   <= w_d2_side.xs;
            r7_side.ys   <= w_d2_side.ys;
            r7_side.xm   <= w_d2_side.xm;
            r7_side.ym   <= w_d2_side.ym;
            r7_side.zero <= w_d2_side.zero;
        end
    end

    // Sphere height.
    logic             w_s2_v;
    logic [MW-1:0]    w_s2_z;
    snm_pkg::t_side_c w_s2_side;

    snm_sqrt_pipe #(
        .RAD_W  (2*MW),
        .SIDE_W ($bits(snm_pkg::t_side_c))
    ) u_height_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_rad   (r7_rad),
        .i_side  (r7_side),
        .o_valid (w_s2_v),
        .o_root  (w_s2_z),
        .o_side  (w_s2_side)
    );

    // Output register: colour encoding of the three components.
    logic                r_out_v;
    snm_pkg::t_pixel_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.red   <= snm_pkg::encode(w_s2_side.xm, w_s2_side.xs);
            r_out.green <= snm_pkg::encode(w_s2_side.ym, w_s2_side.ys);
            r_out.blue  <= snm_pkg::encode(w_s2_side.zero ? '0 : w_s2_z, 1'b0);
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// File: src/snm_checker.sv
`timescale 1ns / 1ps

module snm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input snm_pkg::t_pixel_in  i_data,
    input logic                o_valid,
    input logic                i_ready,
    input snm_pkg::t_pixel_out o_data
);

    // A waiting output beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // A stalled output stops intake.
    a_stall_blocks: assert property (@(posedge i_clk)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while output stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // The height is never negative, so blue never falls below mid scale.
    a_blue_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.blue >= 8'd127)
        else $error("blue below mid scale");

endmodule

bind sphere_normal_map_pixel_unit snm_checker u_snm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
